// ===== hw/rtl/espd_pkg.sv =====
// Shared types and constants for the encoder speed PD motor loop.
`default_nettype none
package espd_pkg;

    localparam int unsigned DUTY_W   = 14;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned TGT_W    = 8;
    localparam int unsigned CH_NUM   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 14;
    // wide enough for duty + target - 2*speed + prev speed without overflow
    localparam int unsigned SUM_W    = 19;

    localparam logic [TGT_W-1:0]  RST_RUN_SPEED   = 8'd4;
    localparam logic [DUTY_W-1:0] RST_DUTY_MIN    = 14'd508;
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX    = 14'd1016;
    localparam logic [DUTY_W-1:0] RST_DUTY_CENTER = 14'd745;
    localparam logic [1:0]        RST_INVERT      = 2'd2;

    typedef enum logic [1:0] {
        MODE_EDGE   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_SET    = 2'd2,
        MODE_BUTTON = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_SPEED   = 3'd0,
        CFG_DUTY_MIN    = 3'd1,
        CFG_DUTY_MAX    = 3'd2,
        CFG_DUTY_CENTER = 3'd3,
        CFG_INVERT      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        mode_t             mode;
        logic              channel;
        logic              phase_b;
        logic [DUTY_W-1:0] duty_value;
    } item_t;

    typedef struct packed {
        logic [TGT_W-1:0]  run_speed;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [1:0]        invert;
    } cfg_t;

    typedef struct packed {
        logic              channel;
        logic [DUTY_W-1:0] duty;
        logic [POS_W-1:0]  speed;
        logic              running;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/espd_core.sv =====
// Loop state (per-channel position, speed and duty; shared run flag and target) and the update for one request.
`default_nettype none
module espd_core
    import espd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      res
);

    logic [POS_W-1:0]  pos_reg      [CH_NUM];
    logic [POS_W-1:0]  last_pos_reg [CH_NUM];
    logic [POS_W-1:0]  cur_spd_reg  [CH_NUM];
    logic [POS_W-1:0]  prev_spd_reg [CH_NUM];
    logic [DUTY_W-1:0] duty_reg     [CH_NUM];
    logic              run_reg;
    logic [TGT_W-1:0]  target_reg;

    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  last_pos_next;
    logic [POS_W-1:0]  cur_spd_next;
    logic [POS_W-1:0]  prev_spd_next;
    logic [DUTY_W-1:0] duty_next;
    logic              run_next;
    logic [TGT_W-1:0]  target_next;

    logic              ch;
    logic              count_up;
    logic [POS_W-1:0]  pos_stepped;
    logic [POS_W-1:0]  meas_spd;
    logic signed [SUM_W-1:0] sp_ext;
    logic signed [SUM_W-1:0] ps_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lo_clamped;
    logic signed [SUM_W-1:0] clamped;
    logic signed [SUM_W-1:0] min_ext;
    logic signed [SUM_W-1:0] max_ext;

    assign ch = item.channel;

    always_comb
    begin
        count_up    = ~item.phase_b ^ cfg.invert[ch];
        pos_stepped = count_up ? pos_reg[ch] + POS_W'(1) : pos_reg[ch] - POS_W'(1);
        meas_spd    = pos_reg[ch] - last_pos_reg[ch];

        sp_ext  = SUM_W'(signed'(meas_spd));
        ps_ext  = SUM_W'(signed'(cur_spd_reg[ch]));
        min_ext = signed'(SUM_W'(cfg.duty_min));
        max_ext = signed'(SUM_W'(cfg.duty_max));
        sum     = signed'(SUM_W'(duty_reg[ch])) + signed'(SUM_W'(target_reg))
                  - sp_ext - sp_ext + ps_ext;
        // low limit first, high limit wins when limits cross
        lo_clamped = (sum < min_ext) ? min_ext : sum;
        clamped    = (lo_clamped > max_ext) ? max_ext : lo_clamped;

        pos_next      = pos_reg[ch];
        last_pos_next = last_pos_reg[ch];
        cur_spd_next  = cur_spd_reg[ch];
        prev_spd_next = prev_spd_reg[ch];
        duty_next     = duty_reg[ch];
        run_next      = run_reg;
        target_next   = target_reg;

        case (item.mode)
            MODE_EDGE:
            begin
                pos_next = pos_stepped;
            end
            MODE_TICK:
            begin
                prev_spd_next = cur_spd_reg[ch];
                cur_spd_next  = meas_spd;
                last_pos_next = pos_reg[ch];
                duty_next     = clamped[DUTY_W-1:0];
            end
            MODE_SET:
            begin
                duty_next = item.duty_value;
            end
            MODE_BUTTON:
            begin
                run_next    = ~run_reg;
                target_next = run_reg ? '0 : cfg.run_speed;
            end
            default:
            begin
                pos_next = pos_reg[ch];
            end
        endcase

        res.channel = ch;
        res.duty    = duty_next;
        res.speed   = cur_spd_next;
        res.running = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_NUM; i++)
            begin
                pos_reg[i]      <= '0;
                last_pos_reg[i] <= '0;
                cur_spd_reg[i]  <= '0;
                prev_spd_reg[i] <= '0;
                duty_reg[i]     <= RST_DUTY_CENTER;
            end
            run_reg    <= 1'b0;
            target_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg[ch]      <= pos_next;
            last_pos_reg[ch] <= last_pos_next;
            cur_spd_reg[ch]  <= cur_spd_next;
            prev_spd_reg[ch] <= prev_spd_next;
            duty_reg[ch]     <= duty_next;
            run_reg          <= run_next;
            target_reg       <= target_next;
        end
    end

    a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_EDGE) |=>
            ((pos_reg[$past(ch)] - $past(pos_reg[ch])) == POS_W'(1) ||
             (pos_reg[$past(ch)] - $past(pos_reg[ch])) == {POS_W{1'b1}}))
        else $error("encoder edge did not step position by one");

    a_tick_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_TICK && cfg.duty_min <= cfg.duty_max) |=>
            (duty_reg[$past(ch)] >= $past(cfg.duty_min) &&
             duty_reg[$past(ch)] <= $past(cfg.duty_max)))
        else $error("duty after tick outside limits");

    a_button_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_BUTTON) |=>
            (run_reg != $past(run_reg) && (run_reg || target_reg == '0)))
        else $error("run button did not toggle run mode");

endmodule
`default_nettype wire

// ===== hw/rtl/encoder_speed_pd_motor_loop.sv =====
// Top level of the two-channel encoder speed PD motor loop.
`default_nettype none
// Two-channel motor speed loop. Each request carries a mode: an encoder edge
// steps the channel's 16-bit wrapping position (phase B low counts up unless
// the channel's invert bit is set), a speed tick measures counts since the
// last tick and adds (target - speed) - (speed - previous speed) to the
// channel's duty, clamped to [duty_min, duty_max] with duty_max winning if
// the limits cross, a set-duty request loads duty_value unclamped, and a run
// button toggles run mode, latching run_speed (or 0) as the target. Every
// request returns one result with the channel's duty, last speed and the run
// flag. Throughput is one request per clock while the output is not stalled;
// a result passes through an input register, then a result register, and
// the loop state is updated as the request moves between them.
// The config port never stalls. Writes to duty_center are taken but reset
// always loads both duties with 745.
module encoder_speed_pd_motor_loop
    import espd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            mode,
    input  wire logic                  channel,
    input  wire logic                  phase_b,
    input  wire logic [DUTY_W-1:0]     duty_value,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       out_channel,
    output logic [DUTY_W-1:0]          duty,
    output logic signed [POS_W-1:0]    speed,
    output logic                       running,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // input stage
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    // result stage
    result_t res_reg;
    logic    out_valid_reg;
    // config registers
    cfg_t    cfg_reg;

    logic    accept;
    logic    adv;       // result stage can take a new result
    logic    move;      // input stage request is processed this cycle
    result_t res_next;

    assign adv      = ~out_valid_reg | ~out_stall;
    assign move     = s1_valid_reg & adv;
    assign in_stall = s1_valid_reg & ~adv;
    assign accept   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.mode       <= mode_t'(mode);
            s1_item_reg.channel    <= channel;
            s1_item_reg.phase_b    <= phase_b;
            s1_item_reg.duty_value <= duty_value;
        end
    end

    // state update happens together with the move into the result stage
    espd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (move),
        .item  (s1_item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = res_reg.channel;
    assign duty        = res_reg.duty;
    assign speed       = signed'(res_reg.speed);
    assign running     = res_reg.running;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_speed <= RST_RUN_SPEED;
            cfg_reg.duty_min  <= RST_DUTY_MIN;
            cfg_reg.duty_max  <= RST_DUTY_MAX;
            cfg_reg.invert    <= RST_INVERT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RUN_SPEED:   cfg_reg.run_speed <= cfg_data[TGT_W-1:0];
                CFG_DUTY_MIN:    cfg_reg.duty_min  <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MAX:    cfg_reg.duty_max  <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_CENTER: ; // ignored; reset always loads 745
                CFG_INVERT:      cfg_reg.invert    <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input stage lost a blocked request");

    a_move_result: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("processed request produced no result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
